// ===== src/prqa_pkg.sv =====
// Shared types and constants for the pooled ready queues with aging.
// Holds command, status and sequencer state codes and the fixed field widths.
// No dependencies.
package prqa_pkg;

  localparam int PROC_W = 6;
  localparam int CNT_W = 7;
  localparam int TIME_W = 32;
  localparam int THR_W = 31;
  localparam int SEL_W = 2;
  localparam int IN_TDATA_W = 80;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SPLIT,
    CMD_LENGTH
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY,
    STAT_SAME
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_GET,
    ST_PUSH_WRITE,
    ST_POP_DONE,
    ST_SPLIT_WALK,
    ST_SPLIT_SRC,
    ST_SPLIT_DST,
    ST_RESULT
  } state_t;

endpackage

// ===== src/prqa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module prqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/prqa_age_unit.sv =====
// Age compare unit shared by every step of the split walk.
// Depends on prqa_pkg for the time and threshold widths.
module prqa_age_unit
  import prqa_pkg::*;
(
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] stamp,
  input  logic [THR_W-1:0]  thr,
  output logic              aged
);

  logic [TIME_W-1:0] age;

  assign age  = now - stamp;
  assign aged = age > TIME_W'(thr);

endmodule

// ===== src/pooled_ready_queues_with_aging.sv =====
// Top level of the pooled ready queues with aging.
// Depends on prqa_pkg, prqa_ram and prqa_age_unit.
//
// One request is taken at a time and answered by exactly one result; the next
// request is accepted while that result still waits in the output register.
// A length request, a push onto a full pool, a pop of an empty queue and a split
// onto its own queue or from an empty queue go from decode to the result step.
// A pop passes through the pop step, a push through the write step and, when it
// reuses a freed node, first through the free-stack read. A split walks its aged
// entries, then updates the source and then the target queue; it skips both
// updates when nothing is aged. The walk reads one node a cycle from the stamp and
// link memories and ages it in the shared compare unit. A result that still
// waits in the output register holds the sequencer in its last step until it
// is taken. Nodes come from a free stack of released nodes or, while any
// remain, from a counter of never-used nodes, so no clearing pass follows reset.
module pooled_ready_queues_with_aging
  import prqa_pkg::*;
#(
  parameter int POOL_SIZE = 64,
  parameter int QUEUE_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command, queue_select, target_queue, process_number, current_time,
  // age_threshold, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // process_out, entry_count, status, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int QW = $clog2(QUEUE_COUNT);

  state_t state, state_next;

  logic [IW-1:0] head [QUEUE_COUNT];
  logic [IW-1:0] tail [QUEUE_COUNT];
  logic [LW-1:0] len  [QUEUE_COUNT];
  logic [LW-1:0] fresh;
  logic [LW-1:0] free_top;

  cmd_t              cmd;
  logic [QW-1:0]     q;
  logic [QW-1:0]     t;
  logic [PROC_W-1:0] proc;
  logic [TIME_W-1:0] now;
  logic [THR_W-1:0]  thr;
  logic [IW-1:0]     node;
  logic [IW-1:0]     cur;
  logic [IW-1:0]     first;
  logic [IW-1:0]     last;
  logic [LW-1:0]     moved;
  logic [LW-1:0]     src_len;
  logic [PROC_W-1:0] res_proc;
  logic [LW-1:0]     res_count;
  status_t           res_status;

  logic [4:0]    qs_wide, ts_wide, q_wide, t_wide;
  logic [QW-1:0] sel;
  logic [IW-1:0] sel_head, sel_tail;
  logic [LW-1:0] sel_len;
  logic [LW-1:0] moved_inc;
  logic [LW-1:0] free_top_dec;
  logic [15:0]   count_ext;
  logic          out_free;
  logic          aged;

  logic              node_we_proc, node_we_stamp, node_we_link, free_we;
  logic [IW-1:0]     node_raddr, stamp_waddr, link_waddr;
  logic [TIME_W-1:0] stamp_wdata;
  logic [IW-1:0]     link_wdata;
  logic [PROC_W-1:0] proc_rdata;
  logic [TIME_W-1:0] stamp_rdata;
  logic [IW-1:0]     link_rdata;
  logic [IW-1:0]     free_rdata;

  assign qs_wide = {3'b000, s_tdata[3:2]};
  assign ts_wide = {3'b000, s_tdata[5:4]};
  assign q_wide  = (qs_wide >= 5'(QUEUE_COUNT)) ? qs_wide - 5'(QUEUE_COUNT) : qs_wide;
  assign t_wide  = (ts_wide >= 5'(QUEUE_COUNT)) ? ts_wide - 5'(QUEUE_COUNT) : ts_wide;

  assign sel          = (state == ST_SPLIT_DST) ? t : q;
  assign sel_head     = head[sel];
  assign sel_tail     = tail[sel];
  assign sel_len      = len[sel];
  assign moved_inc    = moved + LW'(1);
  assign free_top_dec = free_top - LW'(1);
  assign count_ext    = 16'(res_count);
  assign out_free     = !m_tvalid || m_tready;
  assign s_tready     = (state == ST_IDLE);

  prqa_age_unit u_age (
    .now   (now),
    .stamp (stamp_rdata),
    .thr   (thr),
    .aged  (aged)
  );

  prqa_ram #(.WIDTH(PROC_W), .DEPTH(POOL_SIZE)) u_proc_ram (
    .clk   (clk),
    .we    (node_we_proc),
    .waddr (node),
    .wdata (proc),
    .raddr (node_raddr),
    .rdata (proc_rdata)
  );

  prqa_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SIZE)) u_stamp_ram (
    .clk   (clk),
    .we    (node_we_stamp),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .raddr (node_raddr),
    .rdata (stamp_rdata)
  );

  prqa_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk   (clk),
    .we    (node_we_link),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (node_raddr),
    .rdata (link_rdata)
  );

  prqa_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_top[IW-1:0]),
    .wdata (cur),
    .raddr (free_top_dec[IW-1:0]),
    .rdata (free_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (cmd)
          CMD_PUSH: begin
            if (free_top != '0) begin
              state_next = ST_PUSH_GET;
            end else if (fresh != LW'(POOL_SIZE)) begin
              state_next = ST_PUSH_WRITE;
            end else begin
              state_next = ST_RESULT;
            end
          end
          CMD_POP: begin
            state_next = (sel_len == '0) ? ST_RESULT : ST_POP_DONE;
          end
          CMD_SPLIT: begin
            state_next = (q == t || sel_len == '0) ? ST_RESULT : ST_SPLIT_WALK;
          end
          CMD_LENGTH: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_PUSH_GET:   state_next = ST_PUSH_WRITE;
      ST_PUSH_WRITE: state_next = ST_RESULT;
      ST_POP_DONE:   state_next = ST_RESULT;
      ST_SPLIT_WALK: begin
        if (aged) begin
          state_next = (moved_inc == src_len) ? ST_SPLIT_SRC : ST_SPLIT_WALK;
        end else begin
          state_next = (moved == '0) ? ST_RESULT : ST_SPLIT_SRC;
        end
      end
      ST_SPLIT_SRC: state_next = ST_SPLIT_DST;
      ST_SPLIT_DST: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    node_raddr    = cur;
    node_we_proc  = 1'b0;
    node_we_stamp = 1'b0;
    node_we_link  = 1'b0;
    free_we       = 1'b0;
    stamp_waddr   = node;
    stamp_wdata   = now;
    link_waddr    = sel_tail;
    link_wdata    = node;
    unique case (state)
      ST_DECODE: begin
        node_raddr = sel_head;
      end
      ST_PUSH_WRITE: begin
        node_we_proc  = 1'b1;
        node_we_stamp = 1'b1;
        node_we_link  = (sel_len != '0);
      end
      ST_POP_DONE: begin
        free_we = 1'b1;
      end
      ST_SPLIT_WALK: begin
        if (aged) begin
          node_we_stamp = 1'b1;
          stamp_waddr   = cur;
          node_raddr    = link_rdata;
        end
      end
      ST_SPLIT_DST: begin
        node_we_link = (sel_len != '0);
        link_wdata   = first;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      fresh    <= '0;
      free_top <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        len[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_DECODE: begin
          if (cmd == CMD_PUSH) begin
            if (free_top != '0) begin
              free_top <= free_top_dec;
            end else if (fresh != LW'(POOL_SIZE)) begin
              fresh <= fresh + LW'(1);
            end
          end
        end
        ST_PUSH_WRITE: begin
          if (sel_len == '0) begin
            head[sel] <= node;
          end
          tail[sel] <= node;
          len[sel]  <= sel_len + LW'(1);
        end
        ST_POP_DONE: begin
          head[sel] <= link_rdata;
          len[sel]  <= sel_len - LW'(1);
          free_top  <= free_top + LW'(1);
        end
        ST_SPLIT_SRC: begin
          if (moved != src_len) begin
            head[sel] <= cur;
          end
          len[sel] <= src_len - moved;
        end
        ST_SPLIT_DST: begin
          if (sel_len == '0) begin
            head[sel] <= first;
          end
          tail[sel] <= last;
          len[sel]  <= sel_len + moved;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd        <= cmd_t'(s_tdata[1:0]);
          q          <= q_wide[QW-1:0];
          t          <= t_wide[QW-1:0];
          proc       <= s_tdata[11:6];
          now        <= s_tdata[43:12];
          thr        <= s_tdata[74:44];
          res_proc   <= '0;
          res_count  <= '0;
          res_status <= STAT_OK;
        end
      end
      ST_DECODE: begin
        cur     <= sel_head;
        first   <= sel_head;
        moved   <= '0;
        src_len <= sel_len;
        node    <= fresh[IW-1:0];
        unique case (cmd)
          CMD_PUSH: begin
            if (free_top == '0 && fresh == LW'(POOL_SIZE)) begin
              res_status <= STAT_FULL;
            end
          end
          CMD_POP: begin
            if (sel_len == '0) begin
              res_status <= STAT_EMPTY;
            end
          end
          CMD_SPLIT: begin
            if (q == t) begin
              res_status <= STAT_SAME;
            end
          end
          CMD_LENGTH: begin
            res_count <= sel_len;
          end
        endcase
      end
      ST_PUSH_GET: begin
        node <= free_rdata;
      end
      ST_POP_DONE: begin
        res_proc <= proc_rdata;
      end
      ST_SPLIT_WALK: begin
        if (aged) begin
          last  <= cur;
          moved <= moved_inc;
          cur   <= link_rdata;
        end
      end
      ST_SPLIT_DST: begin
        res_count <= moved;
      end
      ST_RESULT: begin
        if (out_free) begin
          m_tdata <= {1'b0, res_status, count_ext[CNT_W-1:0], res_proc};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The pool never hands out more nodes than it has, and every free node was once used.
  assert property (@(posedge clk) disable iff (rst)
    free_top <= fresh && fresh <= LW'(POOL_SIZE))
    else $error("node pool accounting out of range");

  // The split walk never passes the end of the source queue.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SPLIT_WALK |-> moved < src_len)
    else $error("split walk ran past the source queue");

  // A completed pop returns exactly one node to the free stack.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_POP_DONE |=> free_top == $past(free_top) + LW'(1))
    else $error("pop did not release its node");

  // A result is presented only by the final step of the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_RESULT)
    else $error("result presented outside the result step");
`endif

endmodule

// ===== sim/tb_pooled_ready_queues_with_aging.sv =====
// Self-checking testbench for pooled_ready_queues_with_aging: directed and random
// push, pop, split and length requests against a behavioral model of the queues.
// Depends on prqa_pkg and the block's top level.
module tb_pooled_ready_queues_with_aging
  import prqa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_N = 4;
  localparam int POOL_N = 64;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    cmd_t        command;
    logic [1:0]  queue_select;
    logic [1:0]  target_queue;
    logic [5:0]  process_number;
    logic [31:0] current_time;
    logic [30:0] age_threshold;
  } sched_req_t;

  typedef struct {
    logic [5:0] process_out;
    logic [6:0] entry_count;
    status_t    status;
  } sched_reply_t;

  typedef struct {
    logic [5:0]  process_number;
    logic [31:0] stamp;
  } ready_entry_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  ready_entry_t ready_q[QUEUE_N][$];
  int pool_used = 0;
  sched_reply_t expected_replies[$];
  int error_count = 0;
  bit idle_on = 1'b1;
  int stall_requests = 0;
  int idle_cycles = 0;
  logic [31:0] now_tick;

  pooled_ready_queues_with_aging dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic sched_reply_t apply_scheduler_request(input sched_req_t r);
    sched_reply_t res;
    ready_entry_t e;
    int q;
    int t;
    int moved;
    res.process_out = '0;
    res.entry_count = '0;
    res.status = STAT_OK;
    q = int'(r.queue_select);
    t = int'(r.target_queue);
    case (r.command)
      CMD_PUSH: begin
        if (pool_used == POOL_N) begin
          res.status = STAT_FULL;
        end else begin
          e.process_number = r.process_number;
          e.stamp = r.current_time;
          ready_q[q].push_back(e);
          pool_used++;
        end
      end
      CMD_POP: begin
        if (ready_q[q].size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          e = ready_q[q].pop_front();
          res.process_out = e.process_number;
          pool_used--;
        end
      end
      CMD_SPLIT: begin
        if (q == t) begin
          res.status = STAT_SAME;
        end else begin
          moved = 0;
          // The aged run leaves the source head in order and lands at the target tail.
          while (ready_q[q].size() != 0 &&
                 (r.current_time - ready_q[q][0].stamp) > {1'b0, r.age_threshold}) begin
            e = ready_q[q].pop_front();
            e.stamp = r.current_time;
            ready_q[t].push_back(e);
            moved++;
          end
          res.entry_count = 7'(moved);
        end
      end
      default: begin
        res.entry_count = 7'(ready_q[q].size());
      end
    endcase
    return res;
  endfunction

  function automatic sched_req_t make_req(input cmd_t c, input int sel, input int tgt,
                                          input int proc, input logic [31:0] tm,
                                          input logic [30:0] thr);
    sched_req_t r;
    r.command = c;
    r.queue_select = 2'(sel);
    r.target_queue = 2'(tgt);
    r.process_number = 6'(proc);
    r.current_time = tm;
    r.age_threshold = thr;
    return r;
  endfunction

  task automatic send_request(input sched_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, r.age_threshold, r.current_time, r.process_number,
                r.target_queue, r.queue_select, r.command};
    do @(posedge clk); while (!s_tready);
    expected_replies.push_back(apply_scheduler_request(r));
  endtask

  initial begin : reply_sink
    int wait_left;
    int hold_left;
    int stalls_seen;
    sched_reply_t got;
    sched_reply_t want;
    wait_left = 0;
    hold_left = 0;
    stalls_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.process_out = m_tdata[5:0];
        got.entry_count = m_tdata[12:6];
        got.status = status_t'(m_tdata[14:13]);
        if (expected_replies.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_replies.pop_front();
          if (got.process_out !== want.process_out)
            report_mismatch($sformatf("process_out %0d, expected %0d",
                                      got.process_out, want.process_out));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
        end
        wait_left = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR at %0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_empty_queues();
    for (int q = 0; q < QUEUE_N; q++) begin
      send_request(make_req(CMD_LENGTH, q, 0, 0, now_tick, 31'd0));
      send_request(make_req(CMD_POP, q, 0, 0, now_tick, 31'd0));
    end
    send_request(make_req(CMD_SPLIT, 0, 0, 0, now_tick, 31'd0));
    send_request(make_req(CMD_SPLIT, 1, 2, 0, now_tick, 31'd0));
  endtask

  task automatic test_push_pop_order();
    send_request(make_req(CMD_PUSH, 3, 0, 63, 32'hFFFF_FFFF, 31'd0));
    send_request(make_req(CMD_PUSH, 3, 0, 0, 32'h0000_0000, 31'd0));
    send_request(make_req(CMD_POP, 3, 0, 0, 32'h0, 31'd0));
    send_request(make_req(CMD_LENGTH, 3, 0, 0, 32'h0, 31'd0));
    send_request(make_req(CMD_POP, 3, 0, 0, 32'h0, 31'd0));
  endtask

  task automatic test_split_aging();
    logic [31:0] base;
    base = 32'hFFFF_FFF0;
    send_request(make_req(CMD_PUSH, 0, 0, 1, base, 31'd0));
    send_request(make_req(CMD_PUSH, 0, 0, 2, base + 32'd10, 31'd0));
    send_request(make_req(CMD_PUSH, 0, 0, 3, base + 32'd20, 31'd0));
    send_request(make_req(CMD_SPLIT, 0, 1, 0, base + 32'd25, 31'd10));
    send_request(make_req(CMD_LENGTH, 1, 0, 0, base, 31'd0));
    send_request(make_req(CMD_LENGTH, 0, 0, 0, base, 31'd0));
    send_request(make_req(CMD_SPLIT, 0, 1, 0, base + 32'd25, 31'h7FFF_FFFF));
    // A time before the stamps gives a huge unsigned age, so the whole queue moves.
    send_request(make_req(CMD_SPLIT, 1, 0, 0, base + 32'd24, 31'h7FFF_FFFF));
    send_request(make_req(CMD_LENGTH, 1, 0, 0, base, 31'd0));
    for (int i = 0; i < 3; i++)
      send_request(make_req(CMD_POP, 0, 0, 0, base, 31'd0));
  endtask

  task automatic advance_tick();
    if ($urandom_range(0, 49) == 0)
      now_tick = $urandom;
    else
      now_tick = now_tick + 32'($urandom_range(0, 40));
  endtask

  function automatic logic [30:0] draw_threshold();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'($urandom);
      default: return 31'($urandom_range(0, 150));
    endcase
  endfunction

  task automatic test_pool_exhaust();
    stall_requests++;
    for (int i = 0; i < POOL_N + 8; i++) begin
      advance_tick();
      send_request(make_req(CMD_PUSH, $urandom_range(0, 3), 0, $urandom_range(0, 63),
                            now_tick, 31'd0));
    end
    for (int q = 0; q < QUEUE_N; q++) begin
      send_request(make_req(CMD_LENGTH, q, 0, 0, now_tick, 31'd0));
      while (ready_q[q].size() != 0)
        send_request(make_req(CMD_POP, q, 0, 0, now_tick, 31'd0));
      send_request(make_req(CMD_POP, q, 0, 0, now_tick, 31'd0));
    end
  endtask

  task automatic test_random_mix(input int count, input int push_pct);
    int pick;
    int rest;
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 63) == 0)
        idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      rest = 100 - push_pct;
      if (pick < push_pct)
        c = CMD_PUSH;
      else if (pick < push_pct + rest * 2 / 5)
        c = CMD_POP;
      else if (pick < push_pct + rest * 4 / 5)
        c = CMD_SPLIT;
      else
        c = CMD_LENGTH;
      advance_tick();
      send_request(make_req(c, $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 63), now_tick, draw_threshold()));
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    now_tick = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queues();
    test_push_pop_order();
    test_split_aging();
    test_pool_exhaust();
    test_random_mix(450, 70);
    test_random_mix(450, 45);
    test_random_mix(450, 25);
    idle_on = 1'b0;
    test_random_mix(250, 50);
    idle_on = 1'b1;
    test_random_mix(250, 55);
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/prqa_pkg.sv
src/prqa_ram.sv
src/prqa_age_unit.sv
src/pooled_ready_queues_with_aging.sv
sim/tb_pooled_ready_queues_with_aging.sv
